// ===== sv/qas_pkg.sv =====
`default_nettype none

package qas_pkg;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_QUOTE  = 2'd1,
    FAULT_ESCAPE = 2'd2
  } fault_e;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       arg_done;
    logic       line_done;
    fault_e     fault;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/qas_core.sv =====
`default_nettype none

module qas_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire logic [7:0]       in_char_i,
  input  wire logic             line_over_i,
  output logic                  res_valid_o,
  output qas_pkg::result_t      res_o
);
  import qas_pkg::*;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  quote_e open_quote_q, open_quote_d;
  logic   escape_q, escape_d;
  logic   nonempty_q, nonempty_d;
  logic   quoted_q, quoted_d;
  quote_e kind;

  // emit a literal character into the current argument
  function automatic result_t lit(input logic [7:0] c);
    result_t r;
    r            = '0;
    r.out_char   = c;
    r.char_valid = 1'b1;
    r.fault      = FAULT_NONE;
    return r;
  endfunction

  always_comb begin
    open_quote_d = open_quote_q;
    escape_d     = escape_q;
    nonempty_d   = nonempty_q;
    quoted_d     = quoted_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.fault  = FAULT_NONE;
    kind         = (in_char_i == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;

    if (line_over_i) begin
      res_valid_o     = 1'b1;
      res_o.line_done = 1'b1;
      if (open_quote_q != QUOTE_NONE) begin
        res_o.fault = FAULT_QUOTE;
      end else if (escape_q) begin
        res_o.fault = FAULT_ESCAPE;
      end else begin
        res_o.arg_done = nonempty_q;
      end
      open_quote_d = QUOTE_NONE;
      escape_d     = 1'b0;
      nonempty_d   = 1'b0;
      quoted_d     = 1'b0;
    end else if (in_char_i == CH_CR || in_char_i == CH_LF) begin
      // drop, a pending escape stays pending
    end else if (escape_q) begin
      escape_d    = 1'b0;
      nonempty_d  = 1'b1;
      res_valid_o = 1'b1;
      res_o       = lit(in_char_i);
    end else if (in_char_i == CH_BSLASH) begin
      escape_d = 1'b1;
    end else if (in_char_i == CH_DQUOTE || in_char_i == CH_SQUOTE) begin
      if (open_quote_q == kind) begin
        open_quote_d = QUOTE_NONE;
      end else if (open_quote_q == QUOTE_NONE) begin
        open_quote_d = kind;
        quoted_d     = 1'b1;
      end else begin
        // quote of the other kind inside a span is literal
        nonempty_d  = 1'b1;
        res_valid_o = 1'b1;
        res_o       = lit(in_char_i);
      end
    end else if (in_char_i == CH_SPACE && open_quote_q == QUOTE_NONE) begin
      if (nonempty_q || quoted_q) begin
        nonempty_d     = 1'b0;
        quoted_d       = 1'b0;
        res_valid_o    = 1'b1;
        res_o.arg_done = 1'b1;
      end
    end else begin
      nonempty_d  = 1'b1;
      res_valid_o = 1'b1;
      res_o       = lit(in_char_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_quote_q <= QUOTE_NONE;
      escape_q     <= 1'b0;
      nonempty_q   <= 1'b0;
      quoted_q     <= 1'b0;
    end else if (advance_i) begin
      open_quote_q <= open_quote_d;
      escape_q     <= escape_d;
      nonempty_q   <= nonempty_d;
      quoted_q     <= quoted_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/quoted_argument_splitter_unit.sv =====
`default_nettype none

// Shell-style argument splitter. Takes one character per cycle on the slave
// stream while tready is high, and emits at most one registered result per
// character on the master stream: each argument character, an argument end
// (tlast), and one line-end result (tuser line_done) carrying a fault code for
// an unclosed quote or a dangling backslash. Dropped characters (CR, LF, quotes
// that open or close a span, an escaping backslash, extra spaces) give no
// result. The per-character decision is a single combinational step on the
// tokenizer state; a two-entry output buffer keeps tready registered, so the
// rate stays at one character per cycle as long as the master side takes results.
module quoted_argument_splitter_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic       s_axis_tuser,   // [0] line_over
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic            m_axis_tlast,   // arg_done
  output logic [3:0]      m_axis_tuser    // [0] char_valid, [1] line_done, [3:2] fault
);
  import qas_pkg::*;

  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  qas_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (in_fire),
    .in_char_i   (s_axis_tdata),
    .line_over_i (s_axis_tuser),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // no input taken while the skid entry is full
      if (m_axis_tready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_char;
  assign m_axis_tlast  = out_q.arg_done;
  assign m_axis_tuser  = {out_q.fault, out_q.line_done, out_q.char_valid};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_line_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata == 8'h00)
    else $error("line-end result carries a character");

  a_fault_no_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3:2] != FAULT_NONE |-> !m_axis_tlast && m_axis_tuser[1])
    else $error("fault outside a line-end result or with argument end");

  a_char_xor_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast && m_axis_tuser[3:2] == FAULT_NONE)
    else $error("character result also marks an end");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !m_axis_tready |=> skid_valid_q && $stable(skid_q))
    else $error("skid entry lost under stall");

endmodule

`default_nettype wire

// ===== bench/quoted_argument_splitter_unit_tb.sv =====
`timescale 1ns / 1ps

module quoted_argument_splitter_unit_tb;
  import qas_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned QUIET_TAIL   = 300;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  class token_scoreboard;
    quote_e      open_quote;
    bit          escape_pending;
    bit          arg_nonempty;
    bit          arg_quoted;
    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned failures;
    int unsigned checked;
    int unsigned chars_seen;
    int unsigned lines_seen;
    int unsigned arg_ends;
    int unsigned faulted_lines;

    function new();
      clear_tokenizer();
      mismatches    = 0;
      failures      = 0;
      checked       = 0;
      chars_seen    = 0;
      lines_seen    = 0;
      arg_ends      = 0;
      faulted_lines = 0;
    endfunction

    function void clear_tokenizer();
      open_quote     = QUOTE_NONE;
      escape_pending = 1'b0;
      arg_nonempty   = 1'b0;
      arg_quoted     = 1'b0;
    endfunction

    // Advance the tokenizer by one accepted transaction and queue its result.
    function void note_char(logic [7:0] ch, logic eol);
      result_t r;
      bit      emit;
      quote_e  kind;
      r    = '0;
      emit = 1'b0;
      if (eol) begin
        lines_seen++;
        emit        = 1'b1;
        r.line_done = 1'b1;
        if (open_quote != QUOTE_NONE) begin
          r.fault = FAULT_QUOTE;
        end else if (escape_pending) begin
          r.fault = FAULT_ESCAPE;
        end else begin
          r.arg_done = arg_nonempty;
        end
        if (r.fault != FAULT_NONE) faulted_lines++;
        clear_tokenizer();
      end else begin
        chars_seen++;
        if (ch == CH_CR || ch == CH_LF) begin
          emit = 1'b0;
        end else if (escape_pending) begin
          escape_pending = 1'b0;
          arg_nonempty   = 1'b1;
          emit           = 1'b1;
        end else if (ch == CH_BSLASH) begin
          escape_pending = 1'b1;
        end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
          kind = (ch == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
          if (open_quote == kind) begin
            open_quote = QUOTE_NONE;
          end else if (open_quote == QUOTE_NONE) begin
            open_quote = kind;
            arg_quoted = 1'b1;
          end else begin
            // other kind of quote inside a span is literal
            arg_nonempty = 1'b1;
            emit         = 1'b1;
          end
        end else if (ch == CH_SPACE && open_quote == QUOTE_NONE) begin
          if (arg_nonempty || arg_quoted) begin
            arg_nonempty = 1'b0;
            arg_quoted   = 1'b0;
            emit         = 1'b1;
            r.arg_done   = 1'b1;
          end
        end else begin
          arg_nonempty = 1'b1;
          emit         = 1'b1;
        end
        if (emit && !r.arg_done) begin
          r.out_char   = ch;
          r.char_valid = 1'b1;
        end
      end
      if (emit) begin
        if (r.arg_done) arg_ends++;
        pending_results.push_back(r);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: char=%02h valid=%0b done=%0b line=%0b fault=%0d",
                   got.out_char, got.char_valid, got.arg_done, got.line_done, got.fault);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
          got.arg_done !== want.arg_done || got.line_done !== want.line_done ||
          got.fault !== want.fault) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d expected char=%02h valid=%0b done=%0b line=%0b fault=%0d",
                   checked, want.out_char, want.char_valid, want.arg_done, want.line_done,
                   want.fault);
          $display("            actual char=%02h valid=%0b done=%0b line=%0b fault=%0d",
                   got.out_char, got.char_valid, got.arg_done, got.line_done, got.fault);
        end
      end
    endfunction

    function void finish_check();
      if (pending_results.size() != 0) begin
        failures++;
        $display("%0d expected results never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [3:0]  m_axis_tuser;

  logic        idle_on       = 1'b0;
  int unsigned hold_req      = 0;
  int unsigned cycles        = 0;

  token_scoreboard sb = new();

  quoted_argument_splitter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still expected", cycles,
             sb.pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: check every transaction, stall in bursts or on a long hold request.
  initial begin
    int unsigned stall_left;
    int unsigned hold_seen;
    logic        next_ready;
    result_t     got;
    stall_left = 0;
    hold_seen  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.out_char   = m_axis_tdata;
        got.char_valid = m_axis_tuser[0];
        got.arg_done   = m_axis_tlast;
        got.line_done  = m_axis_tuser[1];
        got.fault      = fault_e'(m_axis_tuser[3:2]);
        sb.check_result(got);
      end
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = LONG_HOLD;
      end
      if (!rst_ni) begin
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_axis_tready <= next_ready;
    end
  end

  // Offer one transaction, hold it until accepted, then maybe idle.
  task automatic send_item(input logic [7:0] ch, input logic eol);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_char(ch, eol);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s, input bit end_line);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    if (end_line) send_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h61, 8'h7A));
    do begin
      c = 8'($urandom);
    end while (c == CH_SPACE || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH ||
               c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 55) return CH_SPACE;
    if (r < 63) return CH_DQUOTE;
    if (r < 71) return CH_SQUOTE;
    if (r < 78) return CH_BSLASH;
    if (r < 82) return CH_CR;
    if (r < 86) return CH_LF;
    return 8'($urandom);
  endfunction

  // Mostly well-formed lines with random content, the rest raw noise.
  task automatic send_random_line();
    logic [7:0] q[$];
    logic [7:0] quote_ch;
    logic [7:0] other_ch;
    int unsigned n_args;
    int unsigned n_pieces;
    int unsigned kind;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, 16)) q.push_back(noise_char());
    end else begin
      n_args = $urandom_range(0, 4);
      repeat (n_args) begin
        repeat ($urandom_range(0, 2)) q.push_back(CH_SPACE);
        n_pieces = $urandom_range(1, 3);
        repeat (n_pieces) begin
          kind = $urandom_range(0, 3);
          if (kind == 0) begin
            repeat ($urandom_range(1, 4)) q.push_back(plain_char());
          end else if (kind == 3) begin
            q.push_back(CH_BSLASH);
            if ($urandom_range(0, 7) == 0) q.push_back(CH_LF);
            q.push_back(8'($urandom));
          end else begin
            quote_ch = (kind == 1) ? CH_DQUOTE : CH_SQUOTE;
            other_ch = (kind == 1) ? CH_SQUOTE : CH_DQUOTE;
            q.push_back(quote_ch);
            repeat ($urandom_range(0, 4)) begin
              case ($urandom_range(0, 5))
                0:       q.push_back(CH_SPACE);
                1:       q.push_back(other_ch);
                2: begin
                  q.push_back(CH_BSLASH);
                  q.push_back(8'($urandom));
                end
                3:       q.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
                default: q.push_back(plain_char());
              endcase
            end
            q.push_back(quote_ch);
          end
        end
      end
      if ($urandom_range(0, 3) == 0) q.push_back(CH_SPACE);
    end
    foreach (q[i]) send_item(q[i], 1'b0);
    send_item(8'($urandom), 1'b1);
  endtask

  initial begin
    int unsigned start_items;
    int unsigned done_items;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // quote of the other kind inside a span, space ends the argument
    send_text("a\"x'y\" ", 1'b0);
    // quoted empty argument ends at a space
    send_text("'' ", 1'b0);
    // escape survives CR and LF
    send_text("\\\015\012q", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // line end with junk on the char bus closes the last argument
    send_item(8'hA5, 1'b1);
    send_text("\"", 1'b1);
    send_text("\\", 1'b1);
    // unclosed quote wins over a pending backslash
    send_text("'\\", 1'b1);
    // quoted empty last argument is dropped
    send_text("\"\"", 1'b1);

    start_items = sb.chars_seen + sb.lines_seen;
    done_items  = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items >= RANDOM_ITEMS - QUIET_TAIL)
        idle_on <= 1'b0;
      else
        idle_on <= !(done_items >= 800 && done_items < 950);
      if ((done_items >= 500 && hold_req == 0) || (done_items >= 1200 && hold_req == 1))
        hold_req <= hold_req + 1;
      send_random_line();
      done_items = sb.chars_seen + sb.lines_seen - start_items;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.finish_check();

    $display("Sent %0d characters on %0d lines; checked %0d results", sb.chars_seen,
             sb.lines_seen, sb.checked);
    $display("Saw %0d argument ends and %0d faulted lines; %0d failures", sb.arg_ends,
             sb.faulted_lines, sb.failures);
    if (sb.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/qas_pkg.sv
sv/qas_core.sv
sv/quoted_argument_splitter_unit.sv
bench/quoted_argument_splitter_unit_tb.sv
